/* hw/rtl/ptwa_pkg.sv */
`timescale 1ns / 1ps

package ptwa_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // Item kinds carried on s_tuser
  localparam logic [1:0] KIND_PKT   = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TTL      = 2'd0;
  localparam logic [1:0] CFG_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_EXP_LEN  = 2'd2;

  localparam logic [31:0] TTL_RESET      = 32'd60000;
  localparam logic [31:0] INTERVAL_RESET = 32'd5000;
  localparam logic [7:0]  EXP_LEN_RESET  = 8'd39;

  localparam logic [4:0] CNT_MAX = 5'd31;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] time_ms;
    logic [47:0] src_mac;
    logic [7:0]  pkt_len;
    logic [7:0]  allegiance;
    logic        hunter;
  } item_t;

  typedef struct packed {
    logic [31:0] entry_ttl;
    logic [31:0] broadcast_interval;
    logic [7:0]  expected_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic       new_entry;
    logic       send_broadcast;
    logic [4:0] evicted_count;
    logic [4:0] entry_count;
  } res_t;

  // Identity word of one table entry
  typedef struct packed {
    logic        hunter;
    logic [7:0]  allegiance;
    logic [47:0] mac;
  } ident_t;

endpackage

/* hw/rtl/peer_table_with_aging_unit.sv */
`timescale 1ns / 1ps

// Peer table with aging.
// Slave stream (s_*) carries one event per beat: a received packet, a
// millisecond tick or a start-broadcasting event, selected by s_tuser.
// Master stream (m_*) returns exactly one result beat per accepted beat,
// in order. Configuration (TTL, broadcast interval, expected packet length)
// is written through cfg_we/cfg_addr/cfg_wdata; the user must write it only
// while the unit is idle, the block itself does not enforce this. Timing:
// packets of good length and ticks walk the whole table through the entry
// memories, one read per cycle, in SCAN, then pass DRAIN and FIN before the
// next accept; the walk of the memory read port sets its pace. Bad-length
// packets, start events and unused kinds go from IDLE straight to FIN. The
// result beat is loaded into the output register when FIN hands it over.
// The result sits in an output register; the unit takes the next beat while
// that register still waits on m_tready. If the receiver stalls and a second
// result is ready, the sequencer holds it and s_tready stays low.
// Reset clears all valid bits, the broadcast state and the configuration to
// its defaults (TTL 60000 ms, interval 5000 ms, length 39); table memories
// are not cleared and need no pass after reset.

module peer_table_with_aging_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // time_ms[31:0], src_mac[79:32], pkt_len[87:80], allegiance[95:88],
  // hunter[96], zero fill [103:97]
  input  logic [ptwa_pkg::IN_TDATA_W-1:0]      s_tdata,
  // kind[1:0]
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // status[1:0], new_entry[2], send_broadcast[3], evicted_count[8:4],
  // entry_count[13:9], zero fill [15:14]
  output logic [ptwa_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [ptwa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ptwa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import ptwa_pkg::*;

  cfg_t  cfg;
  item_t item_in;
  res_t  res;
  logic  in_ready;
  logic  res_valid;
  logic  res_ready;
  logic  start;

  // Unpack the incoming beat
  assign item_in.kind       = s_tuser;
  assign item_in.time_ms    = s_tdata[31:0];
  assign item_in.src_mac    = s_tdata[79:32];
  assign item_in.pkt_len    = s_tdata[87:80];
  assign item_in.allegiance = s_tdata[95:88];
  assign item_in.hunter     = s_tdata[96];

  assign s_tready  = in_ready;
  assign start     = s_tvalid && in_ready;

  // Output register is free when empty or draining this cycle
  assign res_ready = !m_tvalid || m_tready;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_ttl          <= TTL_RESET;
      cfg.broadcast_interval <= INTERVAL_RESET;
      cfg.expected_len       <= EXP_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TTL:      cfg.entry_ttl          <= cfg_wdata;
        CFG_INTERVAL: cfg.broadcast_interval <= cfg_wdata;
        CFG_EXP_LEN:  cfg.expected_len       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ptwa_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item_in   (item_in),
    .cfg       (cfg),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished result, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {2'b00, res.entry_count, res.evicted_count, res.send_broadcast,
                  res.new_entry, res.status};
    end
  end

endmodule

/* hw/rtl/ptwa_ram.sv */
`timescale 1ns / 1ps

module ptwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ptwa_seq.sv */
`timescale 1ns / 1ps

module ptwa_seq #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ptwa_pkg::item_t item_in,
  input  ptwa_pkg::cfg_t  cfg,
  output logic            in_ready,
  output logic            res_valid,
  input  logic            res_ready,
  output ptwa_pkg::res_t  res
);

  import ptwa_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  state_t state, state_next;
  item_t  item;

  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ev_cnt;
  logic [IW-1:0] idx;
  logic [IW-1:0] chk_idx;
  logic          chk_vld;
  logic          hit_fnd, free_fnd;
  logic [IW-1:0] hit_idx, free_idx;
  logic [31:0]   last_bc;
  logic          bc_active;

  ident_t        id_rdata, id_wdata;
  logic [31:0]   ls_rdata;
  logic          id_we, ls_we;
  logic [IW-1:0] wr_idx;

  logic          fin_fire;
  logic          is_pkt, is_tick, is_start, bad_len;
  logic          mac_hit, aged, bc_due;
  logic [31:0]   age;
  logic [31:0]   cnt_ext, ev_ext;

  ptwa_ram #(.WIDTH($bits(ident_t)), .DEPTH(TABLE_DEPTH), .AW(IW)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (wr_idx),
    .wdata (id_wdata),
    .raddr (idx),
    .rdata (id_rdata)
  );

  ptwa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH), .AW(IW)) u_ls_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (wr_idx),
    .wdata (item.time_ms),
    .raddr (idx),
    .rdata (ls_rdata)
  );

  assign is_pkt   = (item.kind == KIND_PKT);
  assign is_tick  = (item.kind == KIND_TICK);
  assign is_start = (item.kind == KIND_START);
  assign bad_len  = (item.pkt_len != cfg.expected_len);

  assign mac_hit = chk_vld && valid[chk_idx] && (id_rdata.mac == item.src_mac);
  assign age     = item.time_ms - ls_rdata;
  assign aged    = chk_vld && valid[chk_idx] && (age > cfg.entry_ttl);
  assign bc_due  = bc_active && ((item.time_ms - last_bc) >= cfg.broadcast_interval);

  // Report the count after this step: include the entry a new sender adds
  assign cnt_ext = 32'(cnt) + 32'(is_pkt && !bad_len && !hit_fnd && free_fnd);
  assign ev_ext  = 32'(ev_cnt);

  assign id_wdata.mac        = item.src_mac;
  assign id_wdata.allegiance = item.allegiance;
  assign id_wdata.hunter     = item.hunter;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if ((item_in.kind == KIND_TICK) ||
              ((item_in.kind == KIND_PKT) && (item_in.pkt_len == cfg.expected_len))) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and write strobes
  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_FIN);
    fin_fire  = (state == ST_FIN) && res_ready;
    id_we     = 1'b0;
    ls_we     = 1'b0;
    wr_idx    = hit_fnd ? hit_idx : free_idx;
    res       = '0;
    if (is_pkt) begin
      if (bad_len) begin
        res.status = STAT_BAD_LEN;
      end else if (!hit_fnd && !free_fnd) begin
        res.status = STAT_FULL;
      end else begin
        res.status    = STAT_OK;
        res.new_entry = !hit_fnd;
        ls_we         = fin_fire;
        id_we         = fin_fire && !hit_fnd;
      end
    end
    if (is_tick) begin
      res.send_broadcast = bc_due;
      res.evicted_count  = (ev_ext > 32'(CNT_MAX)) ? CNT_MAX : ev_ext[4:0];
    end
    if (is_start) begin
      res.send_broadcast = 1'b1;
    end
    res.entry_count = (cnt_ext > 32'(CNT_MAX)) ? CNT_MAX : cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      cnt       <= '0;
      ev_cnt    <= '0;
      idx       <= '0;
      chk_vld   <= 1'b0;
      hit_fnd   <= 1'b0;
      free_fnd  <= 1'b0;
      last_bc   <= '0;
      bc_active <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= (state == ST_SCAN);
      if (start && in_ready) begin
        ev_cnt   <= '0;
        hit_fnd  <= 1'b0;
        free_fnd <= 1'b0;
        idx      <= '0;
      end
      if (state == ST_SCAN) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
      // Evaluate the entry read in the previous cycle
      if (chk_vld) begin
        if (is_tick) begin
          if (aged) begin
            valid[chk_idx] <= 1'b0;
            cnt            <= cnt - 1'b1;
            ev_cnt         <= ev_cnt + 1'b1;
          end
        end else begin
          if (mac_hit && !hit_fnd) begin
            hit_fnd <= 1'b1;
          end
          if (!valid[chk_idx] && !free_fnd) begin
            free_fnd <= 1'b1;
          end
        end
      end
      if (fin_fire) begin
        if (id_we) begin
          valid[free_idx] <= 1'b1;
          cnt             <= cnt + 1'b1;
        end
        if (is_start) begin
          bc_active <= 1'b1;
          last_bc   <= item.time_ms;
        end
        if (is_tick && bc_due) begin
          last_bc <= item.time_ms;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && in_ready) begin
      item <= item_in;
    end
    chk_idx <= idx;
    if (chk_vld && !is_tick) begin
      if (mac_hit && !hit_fnd) begin
        hit_idx <= chk_idx;
      end
      if (!valid[chk_idx] && !free_fnd) begin
        free_idx <= chk_idx;
      end
    end
  end

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) == $countones(valid))
    else $error("entry count out of step with valid bits");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == STAT_FULL)) |-> (32'(cnt) == TABLE_DEPTH))
    else $error("table full reported with a free slot");

  a_evict_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.evicted_count != 5'd0)) |-> is_tick)
    else $error("eviction reported outside a tick");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (start && in_ready) |=> !in_ready)
    else $error("item accepted while the previous one is in work");

endmodule
